@@ hw/rtl/bchenc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bchenc_pkg
// Types, code constants and generator construction for the BCH encoder.
// ----------------------------------------------------------------------------
package bchenc_pkg;

  localparam int PKG_MAX_PARITY_BITS = 192;
  localparam int GEN_FULL_W          = 208;

  typedef enum logic [1:0] {
    CODE_NORMAL_T8  = 2'd0,
    CODE_NORMAL_T10 = 2'd1,
    CODE_NORMAL_T12 = 2'd2,
    CODE_SHORT_T12  = 2'd3
  } code_t;

  localparam code_t CODE_RESET = CODE_NORMAL_T12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_parity;
    logic       last;
  } out_item_t;

  localparam logic [16:0] NORMAL_MIN [12] = '{
    17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
    17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3
  };

  localparam logic [16:0] SHORT_MIN [12] = '{
    17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
    17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF
  };

  function automatic int parity_len(input code_t c);
    int l;
    case (c)
      CODE_NORMAL_T8:  l = 128;
      CODE_NORMAL_T10: l = 160;
      CODE_NORMAL_T12: l = 192;
      CODE_SHORT_T12:  l = 168;
      default:         l = 192;
    endcase
    return l;
  endfunction

  // Full generator: product of the first t minimal polynomials.
  function automatic logic [GEN_FULL_W-1:0] gen_full(input code_t c);
    logic [GEN_FULL_W-1:0] acc;
    logic [GEN_FULL_W-1:0] res;
    logic [16:0]           m;
    int                    n;
    acc = GEN_FULL_W'(1);
    case (c)
      CODE_NORMAL_T8:  n = 8;
      CODE_NORMAL_T10: n = 10;
      default:         n = 12;
    endcase
    for (int i = 0; i < 12; i++) begin
      if (i < n) begin
        m   = (c == CODE_SHORT_T12) ? SHORT_MIN[i] : NORMAL_MIN[i];
        res = '0;
        for (int k = 0; k < 17; k++) begin
          if (m[k]) res = res ^ (acc << k);
        end
        acc = res;
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bchenc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bchenc_fifo
// Two-entry queue between the LFSR front end and the output sequencer.
// ----------------------------------------------------------------------------
module bchenc_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = count_r[1];
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bchenc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bchenc_front
// Accepts bytes, runs the byte-wide LFSR division and, at frame end,
// hands the aligned remainder and parity byte count to the queue.
// ----------------------------------------------------------------------------
module bchenc_front #(
  parameter int MAX_PARITY_BITS = bchenc_pkg::PKG_MAX_PARITY_BITS,
  localparam int NBW = $clog2(MAX_PARITY_BITS / 8 + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bchenc_pkg::in_item_t       in_item,
  output logic                            push,
  output bchenc_pkg::in_item_t            push_item,
  output logic [MAX_PARITY_BITS-1:0]      push_par,
  output logic [NBW-1:0]                  push_nb,
  input  wire logic                       q_full
);
  import bchenc_pkg::*;

  localparam int IW = $clog2(MAX_PARITY_BITS);

  function automatic int plen_eff(input code_t c);
    int l;
    l = parity_len(c);
    return (l > MAX_PARITY_BITS) ? MAX_PARITY_BITS : l;
  endfunction

  function automatic logic [MAX_PARITY_BITS-1:0] gen_masked(input code_t c);
    logic [GEN_FULL_W-1:0]      full_g;
    logic [MAX_PARITY_BITS-1:0] g;
    int                         p;
    full_g = gen_full(c);
    p      = plen_eff(c);
    for (int i = 0; i < MAX_PARITY_BITS; i++) begin
      g[i] = (i < p) ? full_g[i] : 1'b0;
    end
    return g;
  endfunction

  function automatic logic [MAX_PARITY_BITS-1:0] mask_of(input code_t c);
    logic [MAX_PARITY_BITS-1:0] mk;
    int                         p;
    p = plen_eff(c);
    for (int i = 0; i < MAX_PARITY_BITS; i++) begin
      mk[i] = (i < p);
    end
    return mk;
  endfunction

  localparam logic [MAX_PARITY_BITS-1:0] GEN0 = gen_masked(CODE_NORMAL_T8);
  localparam logic [MAX_PARITY_BITS-1:0] GEN1 = gen_masked(CODE_NORMAL_T10);
  localparam logic [MAX_PARITY_BITS-1:0] GEN2 = gen_masked(CODE_NORMAL_T12);
  localparam logic [MAX_PARITY_BITS-1:0] GEN3 = gen_masked(CODE_SHORT_T12);
  localparam logic [MAX_PARITY_BITS-1:0] MSK0 = mask_of(CODE_NORMAL_T8);
  localparam logic [MAX_PARITY_BITS-1:0] MSK1 = mask_of(CODE_NORMAL_T10);
  localparam logic [MAX_PARITY_BITS-1:0] MSK2 = mask_of(CODE_NORMAL_T12);
  localparam logic [MAX_PARITY_BITS-1:0] MSK3 = mask_of(CODE_SHORT_T12);
  localparam int P0 = plen_eff(CODE_NORMAL_T8);
  localparam int P1 = plen_eff(CODE_NORMAL_T10);
  localparam int P2 = plen_eff(CODE_NORMAL_T12);
  localparam int P3 = plen_eff(CODE_SHORT_T12);

  code_t                      code_r;
  code_t                      code_nxt;
  logic [MAX_PARITY_BITS-1:0] rem_r;
  logic [MAX_PARITY_BITS-1:0] rem_nxt;
  logic [MAX_PARITY_BITS-1:0] g_sel;
  logic [MAX_PARITY_BITS-1:0] m_sel;
  logic [IW-1:0]              tap_sel;
  logic [MAX_PARITY_BITS-1:0] rem_upd;
  logic                       accept;

  always_comb begin
    case (code_r)
      CODE_NORMAL_T8: begin
        g_sel = GEN0; m_sel = MSK0; tap_sel = IW'(P0 - 1);
      end
      CODE_NORMAL_T10: begin
        g_sel = GEN1; m_sel = MSK1; tap_sel = IW'(P1 - 1);
      end
      CODE_SHORT_T12: begin
        g_sel = GEN3; m_sel = MSK3; tap_sel = IW'(P3 - 1);
      end
      default: begin
        g_sel = GEN2; m_sel = MSK2; tap_sel = IW'(P2 - 1);
      end
    endcase
  end

  // Eight LFSR steps per byte, first bit at the MSB.
  always_comb begin
    logic [MAX_PARITY_BITS-1:0] r;
    logic                       fb;
    r = rem_r;
    for (int j = 7; j >= 0; j--) begin
      fb = in_item.data_byte[j] ^ r[tap_sel];
      r  = (r << 1) & m_sel;
      if (fb) r = r ^ g_sel;
    end
    rem_upd = r;
  end

  // Align the remainder so the highest coefficient sits at the top bit.
  always_comb begin
    case (code_r)
      CODE_NORMAL_T8: begin
        push_par = rem_upd << (MAX_PARITY_BITS - P0);
        push_nb  = NBW'(P0 / 8);
      end
      CODE_NORMAL_T10: begin
        push_par = rem_upd << (MAX_PARITY_BITS - P1);
        push_nb  = NBW'(P1 / 8);
      end
      CODE_SHORT_T12: begin
        push_par = rem_upd << (MAX_PARITY_BITS - P3);
        push_nb  = NBW'(P3 / 8);
      end
      default: begin
        push_par = rem_upd << (MAX_PARITY_BITS - P2);
        push_nb  = NBW'(P2 / 8);
      end
    endcase
  end

  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign push      = accept;
  assign push_item = in_item;

  always_comb begin
    code_nxt = cfg_we ? code_t'(cfg_wdata) : code_r;
    rem_nxt  = rem_r;
    if (accept) begin
      rem_nxt = in_item.frame_end ? '0 : rem_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= CODE_RESET;
      rem_r  <= '0;
    end else begin
      code_r <= code_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bchenc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bchenc_back
// Output sequencer: emits each data byte, then serializes parity bytes
// after a frame end, through a registered output stage.
// ----------------------------------------------------------------------------
module bchenc_back #(
  parameter int MAX_PARITY_BITS = bchenc_pkg::PKG_MAX_PARITY_BITS,
  localparam int NBW = $clog2(MAX_PARITY_BITS / 8 + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_not_empty,
  output logic                             pop,
  input  wire bchenc_pkg::in_item_t        pop_item,
  input  wire logic [MAX_PARITY_BITS-1:0]  pop_par,
  input  wire logic [NBW-1:0]              pop_nb,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bchenc_pkg::out_item_t            out_item
);
  import bchenc_pkg::*;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  out_item_t                  out_item_r;
  out_item_t                  out_item_nxt;
  logic [MAX_PARITY_BITS-1:0] par_sr_r;
  logic [MAX_PARITY_BITS-1:0] par_sr_nxt;
  logic [NBW-1:0]             cnt_r;
  logic [NBW-1:0]             cnt_nxt;
  logic                       slot_free;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    par_sr_nxt    = par_sr_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    if (slot_free) begin
      if (cnt_r != '0) begin
        // parity bytes go out before the next queued item
        out_valid_nxt          = 1'b1;
        out_item_nxt.out_byte  = par_sr_r[MAX_PARITY_BITS-1 -: 8];
        out_item_nxt.is_parity = 1'b1;
        out_item_nxt.last      = (cnt_r == NBW'(1));
        par_sr_nxt             = par_sr_r << 8;
        cnt_nxt                = cnt_r - NBW'(1);
      end else if (q_not_empty) begin
        pop                    = 1'b1;
        out_valid_nxt          = 1'b1;
        out_item_nxt.out_byte  = pop_item.data_byte;
        out_item_nxt.is_parity = 1'b0;
        out_item_nxt.last      = 1'b0;
        if (pop_item.frame_end) begin
          par_sr_nxt = pop_par;
          cnt_nxt    = pop_nb;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    out_item_r <= out_item_nxt;
    par_sr_r   <= par_sr_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/bch_systematic_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bch_systematic_encoder
// Systematic DVB-S2 outer BCH encoder, byte serial, four selectable codes.
// ----------------------------------------------------------------------------
// An accepted data byte passes through the queue and then the output register.
// Throughput: one input byte per cycle; after a frame end the output sequencer
// sends the parity bytes (16, 20, 24 or 21) ahead of the next queued item,
// while the front end keeps taking bytes until the two-entry queue fills.
// Reset: synchronous, active low; clears the remainder, the queue and the
// output stage, and sets the selected code to normal t=12.
module bch_systematic_encoder #(
  parameter int MAX_PARITY_BITS = bchenc_pkg::PKG_MAX_PARITY_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire bchenc_pkg::in_item_t   in_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output bchenc_pkg::out_item_t       out_item
);
  import bchenc_pkg::*;

  localparam int NBW = $clog2(MAX_PARITY_BITS / 8 + 1);
  localparam int QW  = MAX_PARITY_BITS + NBW + $bits(in_item_t);

  logic                       push;
  in_item_t                   push_item;
  logic [MAX_PARITY_BITS-1:0] push_par;
  logic [NBW-1:0]             push_nb;
  logic                       q_full;
  logic                       q_not_empty;
  logic                       pop;
  logic [QW-1:0]              pop_data;
  in_item_t                   pop_item;
  logic [MAX_PARITY_BITS-1:0] pop_par;
  logic [NBW-1:0]             pop_nb;

  bchenc_front #(
    .MAX_PARITY_BITS (MAX_PARITY_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .push_par  (push_par),
    .push_nb   (push_nb),
    .q_full    (q_full)
  );

  bchenc_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_par, push_nb, push_item}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  assign {pop_par, pop_nb, pop_item} = pop_data;

  bchenc_back #(
    .MAX_PARITY_BITS (MAX_PARITY_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .pop_item    (pop_item),
    .pop_par     (pop_par),
    .pop_nb      (pop_nb),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  // last only ever marks a parity byte
  a_last_is_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.is_parity)
    else $error("last set on a data byte");

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_not_empty)
    else $error("pop from empty queue");

  // front end stalls exactly when the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == q_full)
    else $error("input stall does not track queue full");

  // a final parity byte taken leaves no parity pending behind it
  a_last_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.last |=> !(out_valid && out_item.is_parity
      && $past(out_item.is_parity) && !$past(out_valid && out_stall)
      && $past(out_item.last)))
    else $error("parity byte after final parity byte");

endmodule
`default_nettype wire
